// ===== hw/rtl/cbc_pkg.sv =====
// Package: widths, reset values and register indexes for the cylinder-box contact core.
`timescale 1ns / 1ps
package cbc_pkg;
	localparam int unsigned COORD_W_DEF = 32;
	localparam int unsigned CFG_W       = 31;
	localparam int unsigned NORM_W      = 16;
	localparam int unsigned ADDR_W      = 4;
	localparam logic signed [NORM_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic [CFG_W-1:0] RADIUS_RST = 31'd26214;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 31'd117965;
	localparam logic [CFG_W-1:0] SNAP_RST   = 31'd32768;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SNAP   = 2'd2
	} reg_idx_t;
endpackage

// ===== hw/rtl/cbc_sqrt_stage.sv =====
// One restoring square root step: two radicand bits in, one root bit out.
`timescale 1ns / 1ps
module cbc_sqrt_stage #(
	parameter int unsigned RW = 34
) (
	input  logic [2*RW-1:0] rad_in,
	input  logic [RW+1:0]   rem_in,
	input  logic [RW-1:0]   root_in,
	output logic [2*RW-1:0] rad_out,
	output logic [RW+1:0]   rem_out,
	output logic [RW-1:0]   root_out
);
	logic [RW+1:0] trial;
	logic [RW+1:0] shifted;

	// Bring down two bits and try root*4+1.
	always_comb begin
		shifted  = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
		trial    = {root_in, 2'b01};
		rad_out  = {rad_in[2*RW-3:0], 2'b00};
		if (shifted >= trial) begin
			rem_out  = shifted - trial;
			root_out = {root_in[RW-2:0], 1'b1};
		end else begin
			rem_out  = shifted;
			root_out = {root_in[RW-2:0], 1'b0};
		end
	end
endmodule

// ===== hw/rtl/cylinder_box_contact_core.sv =====
// Top level: APB registers and the pipelined cylinder-box contact test.
`timescale 1ns / 1ps
// Usage:
//  Configuration: APB port, radius at 0x0, height at 0x4, snap margin at 0x8,
//  31 bits each, one write per setup/access pair, pready always high.
//  Write registers only while the pipeline is empty.
//  Items: drive the nine coordinates with start; busy is never high, so an
//  item is taken on every cycle start is high. One item per clock.
//  Results: done pulses for one cycle with hit, normal and depth. For any
//  COORD_WIDTH, an item passes four setup stages, 32 square root stages (one
//  root bit each), 15 divider stages (one quotient bit each, x and z side by
//  side) and the output register, where done and the results are registered.
//  Reset clears the registers to their defaults and all stage valid bits;
//  items in flight are dropped. The receiver cannot stall; every result is
//  presented exactly once.
module cylinder_box_contact_core
	import cbc_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = COORD_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [cbc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] box_lo_x,
	input  logic signed [COORD_WIDTH-1:0] box_lo_y,
	input  logic signed [COORD_WIDTH-1:0] box_lo_z,
	input  logic signed [COORD_WIDTH-1:0] box_hi_x,
	input  logic signed [COORD_WIDTH-1:0] box_hi_y,
	input  logic signed [COORD_WIDTH-1:0] box_hi_z,
	output logic done,
	output logic hit,
	output logic signed [cbc_pkg::NORM_W-1:0] norm_x,
	output logic signed [cbc_pkg::NORM_W-1:0] norm_y,
	output logic signed [cbc_pkg::NORM_W-1:0] norm_z,
	output logic [cbc_pkg::CFG_W-1:0] depth
);
	// EW: wide signed working width; RW: root width (|d| < 2^31 so root < 2^32)
	localparam int unsigned EW = (COORD_WIDTH > CFG_W ? COORD_WIDTH : CFG_W) + 3;
	localparam int unsigned RW = CFG_W + 1;
	localparam int unsigned QW = 15;
	localparam int unsigned SQ = RW;
	localparam int unsigned DV = QW;
	localparam int unsigned LAT = 4 + SQ + DV + 1;

	logic [CFG_W-1:0] radius_q, height_q, snap_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			height_q <= HEIGHT_RST;
			snap_q   <= SNAP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_W-1:2])
				2'(REG_RADIUS): radius_q <= pwdata[CFG_W-1:0];
				2'(REG_HEIGHT): height_q <= pwdata[CFG_W-1:0];
				2'(REG_SNAP):   snap_q   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			2'(REG_RADIUS): prdata = {1'b0, radius_q};
			2'(REG_HEIGHT): prdata = {1'b0, height_q};
			2'(REG_SNAP):   prdata = {1'b0, snap_q};
			default:        prdata = '0;
		endcase
	end

	logic go;
	assign go = start & ~busy;

	// Stage 1: extend, vertical test, clamp
	logic signed [EW-1:0] px, py, pz, lx, ly, lz, hx, hy, hz, r, sn, top;
	always_comb begin
		px = EW'(pos_x);    py = EW'(pos_y);    pz = EW'(pos_z);
		lx = EW'(box_lo_x); ly = EW'(box_lo_y); lz = EW'(box_lo_z);
		hx = EW'(box_hi_x); hy = EW'(box_hi_y); hz = EW'(box_hi_z);
		r   = EW'($signed({1'b0, radius_q}));
		sn  = EW'($signed({1'b0, snap_q}));
		top = py + EW'($signed({1'b0, height_q}));
	end

	logic v_s1, vert_s1, in_s1;
	logic signed [EW-1:0] px_s1, pz_s1, lx_s1, lz_s1, hx_s1, hz_s1, r_s1;
	logic signed [EW-1:0] dx_s1, dz_s1, pbot_s1, ptop_s1;
	logic up_s1, dn_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= go;
	end
	always_ff @(posedge clk) begin
		logic signed [EW-1:0] cx, cz;
		cx = (px > hx) ? hx : px;
		cx = (lx > cx) ? lx : cx;
		cz = (pz > hz) ? hz : pz;
		cz = (lz > cz) ? lz : cz;
		vert_s1 <= !(top <= ly || py >= hy);
		in_s1   <= px >= lx && px <= hx && pz >= lz && pz <= hz;
		px_s1 <= px; pz_s1 <= pz; lx_s1 <= lx; lz_s1 <= lz;
		hx_s1 <= hx; hz_s1 <= hz; r_s1 <= r;
		dx_s1 <= px - cx; dz_s1 <= pz - cz;
		pbot_s1 <= hy - py;
		ptop_s1 <= top - ly;
		up_s1 <= py >= hy - sn;
		dn_s1 <= top <= ly + sn;
	end

	// Stage 2: four inside pushes, abs of offsets, reach test
	logic v_s2, vert_s2, in_s2, far_s2, up_s2, dn_s2;
	logic signed [EW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, pbot_s2, ptop_s2, r_s2;
	logic [RW-1:0] ax_s2, az_s2;
	logic sx_s2, sz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		logic signed [EW-1:0] ax, az;
		ax = dx_s1[EW-1] ? -dx_s1 : dx_s1;
		az = dz_s1[EW-1] ? -dz_s1 : dz_s1;
		p0_s2 <= px_s1 - lx_s1 + r_s1;
		p1_s2 <= hx_s1 - px_s1 + r_s1;
		p2_s2 <= pz_s1 - lz_s1 + r_s1;
		p3_s2 <= hz_s1 - pz_s1 + r_s1;
		far_s2 <= ax >= r_s1 || az >= r_s1;
		ax_s2 <= RW'(ax); az_s2 <= RW'(az);
		sx_s2 <= dx_s1[EW-1]; sz_s2 <= dz_s1[EW-1];
		vert_s2 <= vert_s1; in_s2 <= in_s1;
		pbot_s2 <= pbot_s1; ptop_s2 <= ptop_s1; r_s2 <= r_s1;
		up_s2 <= up_s1; dn_s2 <= dn_s1;
	end

	// Stage 3: squares (each 32x32) and inside minimum
	logic v_s3, vert_s3, in_s3, far_s3, up_s3, dn_s3, sx_s3, sz_s3;
	logic [2*RW-1:0] axx_s3, azz_s3, rr_s3;
	logic [RW-1:0] ax_s3, az_s3;
	logic signed [EW-1:0] pin_s3, pbot_s3, ptop_s3, r_s3;
	logic signed [NORM_W-1:0] inx_s3, inz_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		logic signed [EW-1:0] m;
		logic signed [NORM_W-1:0] ix, iz;
		m = p0_s2;
		if (p1_s2 < m) m = p1_s2;
		if (p2_s2 < m) m = p2_s2;
		if (p3_s2 < m) m = p3_s2;
		ix = '0; iz = '0;
		if (m == p0_s2)      ix = -ONE_Q14;
		else if (m == p1_s2) ix = ONE_Q14;
		else if (m == p2_s2) iz = -ONE_Q14;
		else                 iz = ONE_Q14;
		pin_s3 <= m;
		inx_s3 <= ix; inz_s3 <= iz;
		axx_s3 <= ax_s2 * ax_s2;
		azz_s3 <= az_s2 * az_s2;
		rr_s3  <= RW'(r_s2) * RW'(r_s2);
		ax_s3 <= ax_s2; az_s3 <= az_s2; sx_s3 <= sx_s2; sz_s3 <= sz_s2;
		vert_s3 <= vert_s2; in_s3 <= in_s2; far_s3 <= far_s2;
		pbot_s3 <= pbot_s2; ptop_s3 <= ptop_s2; r_s3 <= r_s2;
		up_s3 <= up_s2; dn_s3 <= dn_s2;
	end

	// Stage 4: d2 and its reach compare
	typedef struct packed {
		logic vert, in_fp, miss, up, dn, sx, sz;
		logic [RW-1:0] ax, az;
		logic signed [EW-1:0] pin, pbot, ptop, r;
		logic signed [NORM_W-1:0] inx, inz;
	} side_t;
	logic v_s4;
	logic [2*RW-1:0] d2_s4;
	side_t sd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		logic [2*RW:0] d2;
		d2 = (2*RW+1)'(axx_s3) + (2*RW+1)'(azz_s3);
		d2_s4 <= d2[2*RW-1:0];
		sd_s4.vert <= vert_s3; sd_s4.in_fp <= in_s3;
		sd_s4.miss <= far_s3 || d2 >= (2*RW+1)'(rr_s3);
		sd_s4.up <= up_s3; sd_s4.dn <= dn_s3;
		sd_s4.sx <= sx_s3; sd_s4.sz <= sz_s3;
		sd_s4.ax <= ax_s3; sd_s4.az <= az_s3;
		sd_s4.pin <= pin_s3; sd_s4.pbot <= pbot_s3; sd_s4.ptop <= ptop_s3;
		sd_s4.r <= r_s3; sd_s4.inx <= inx_s3; sd_s4.inz <= inz_s3;
	end

	// Square root: one root bit per stage
	logic          sq_v   [SQ+1];
	side_t         sq_sd  [SQ+1];
	logic [2*RW-1:0] sq_rad [SQ+1];
	logic [RW+1:0] sq_rem [SQ+1];
	logic [RW-1:0] sq_root[SQ+1];
	assign sq_v[0] = v_s4; assign sq_sd[0] = sd_s4; assign sq_rad[0] = d2_s4;
	assign sq_rem[0] = '0; assign sq_root[0] = '0;
	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		logic [2*RW-1:0] rad_n;
		logic [RW+1:0]   rem_n;
		logic [RW-1:0]   root_n;
		cbc_sqrt_stage #(.RW(RW)) u_stage (
			.rad_in(sq_rad[i]), .rem_in(sq_rem[i]), .root_in(sq_root[i]),
			.rad_out(rad_n), .rem_out(rem_n), .root_out(root_n)
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[i+1] <= 1'b0;
			else         sq_v[i+1] <= sq_v[i];
		end
		always_ff @(posedge clk) begin
			sq_sd[i+1] <= sq_sd[i]; sq_rad[i+1] <= rad_n;
			sq_rem[i+1] <= rem_n; sq_root[i+1] <= root_n;
		end
	end

	// Divide |dx|<<14 and |dz|<<14 by dist: one quotient bit per stage
	logic          dv_v  [DV+1];
	side_t         dv_sd [DV+1];
	logic [RW-1:0] dv_den[DV+1];
	logic [RW:0]   dv_rx [DV+1], dv_rz [DV+1];
	logic [QW-1:0] dv_qx [DV+1], dv_qz [DV+1];
	assign dv_v[0] = sq_v[SQ]; assign dv_sd[0] = sq_sd[SQ];
	assign dv_den[0] = sq_root[SQ];
	// start from |d|>>1; stage 0 brings down d[0], later stages bring down zeros
	assign dv_rx[0] = (RW+1)'(sq_sd[SQ].ax >> 1);
	assign dv_rz[0] = (RW+1)'(sq_sd[SQ].az >> 1);
	assign dv_qx[0] = '0; assign dv_qz[0] = '0;
	for (genvar j = 0; j < DV; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else         dv_v[j+1] <= dv_v[j];
		end
		always_ff @(posedge clk) begin
			logic [RW+1:0] tx, tz;
			tx = {dv_rx[j], (j == 0) ? dv_sd[j].ax[0] : 1'b0};
			tz = {dv_rz[j], (j == 0) ? dv_sd[j].az[0] : 1'b0};
			if (tx >= (RW+2)'(dv_den[j])) begin
				dv_rx[j+1] <= (RW+1)'(tx - (RW+2)'(dv_den[j]));
				dv_qx[j+1] <= {dv_qx[j][QW-2:0], 1'b1};
			end else begin
				dv_rx[j+1] <= (RW+1)'(tx);
				dv_qx[j+1] <= {dv_qx[j][QW-2:0], 1'b0};
			end
			if (tz >= (RW+2)'(dv_den[j])) begin
				dv_rz[j+1] <= (RW+1)'(tz - (RW+2)'(dv_den[j]));
				dv_qz[j+1] <= {dv_qz[j][QW-2:0], 1'b1};
			end else begin
				dv_rz[j+1] <= (RW+1)'(tz);
				dv_qz[j+1] <= {dv_qz[j][QW-2:0], 1'b0};
			end
			dv_den[j+1] <= dv_den[j]; dv_sd[j+1] <= dv_sd[j];
		end
	end

	// Final stage: choose push and form the result
	side_t fs;
	logic [RW-1:0] hdist;
	assign fs    = dv_sd[DV];
	assign hdist = dv_den[DV];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[DV];
		end
	end
	always_ff @(posedge clk) begin
		logic signed [EW-1:0] pxz, dep;
		logic signed [NORM_W-1:0] nx, nz, cx, cz, ox, oy, oz;
		logic ok, h;
		cx = (dv_qx[DV] > QW'(16384)) ? ONE_Q14 : $signed({1'b0, dv_qx[DV]});
		cz = (dv_qz[DV] > QW'(16384)) ? ONE_Q14 : $signed({1'b0, dv_qz[DV]});
		if (hdist == '0) begin
			cx = '0; cz = '0;
		end
		if (fs.in_fp) begin
			pxz = fs.pin; nx = fs.inx; nz = fs.inz;
		end else begin
			pxz = fs.r - EW'($signed({1'b0, hdist}));
			nx = fs.sx ? -cx : cx;
			nz = fs.sz ? -cz : cz;
		end
		ok = dv_v[DV] && fs.vert && (fs.in_fp || !fs.miss);
		h = 1'b0; ox = '0; oy = '0; oz = '0;
		dep = '0;
		if (ok && fs.up && fs.pbot < pxz) begin
			h = 1'b1; oy = ONE_Q14; dep = fs.pbot;
		end else if (ok && fs.dn && fs.ptop < pxz) begin
			h = 1'b1; oy = -ONE_Q14; dep = fs.ptop;
		end else if (ok && pxz > 0) begin
			h = 1'b1; ox = nx; oz = nz; dep = pxz;
		end
		hit <= h; norm_x <= ox; norm_y <= oy; norm_z <= oz;
		if (dep < 0) depth <= '0;
		else if (dep > EW'(32'h7FFF_FFFF)) depth <= '1;
		else depth <= dep[CFG_W-1:0];
	end

	// Checks
	logic [LAT-1:0] go_hist_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_hist_q <= '0;
		else         go_hist_q <= {go_hist_q[LAT-2:0], go};
	end
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == go_hist_q[LAT-1]) else $error("result strobe off schedule");
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done) else $error("hit without strobe");
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit && norm_y != 0) |-> (norm_x == 0 && norm_z == 0))
		else $error("vertical push with horizontal normal");
endmodule
